// ----- rtl/rck_pkg.sv -----
// ----------------------------------------------------------------------------
// rck_pkg
// Shared types and constants for the rolling canonical k-mer builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rck_pkg;

  localparam int KW        = 6;    // k and fill count width
  localparam int BASE_W    = 2;    // one nucleotide code
  localparam int WORD_W    = 64;   // packed k-mer word
  localparam int SYM_W     = 8;
  localparam int MAX_K_DEF = 32;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 144;

  // result tdata layout
  localparam int O_FWD   = 0;
  localparam int O_REV   = 64;
  localparam int O_CANON = 128;
  localparam int O_FULL  = 129;
  localparam int O_FILL  = 130;
  localparam int O_DROP  = 136;
  localparam int O_NEW   = 138;
  localparam int O_CLR   = 140;
  localparam int O_USED  = 141;

  localparam logic [KW-1:0] K_RESET = KW'(31);

  typedef enum logic {
    CMD_PUSH  = 1'b0,
    CMD_CLEAR = 1'b1
  } rck_cmd_t;

  // control broadcast to every cell
  typedef struct packed {
    logic              push;
    logic              clear;
    logic [KW-1:0]     k;
    logic [BASE_W-1:0] sym;
  } rck_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/rck_cell.sv -----
// ----------------------------------------------------------------------------
// rck_cell
// One base position: holds two forward bits and two reverse-complement bits.
// Forward data moves up the chain, reverse data moves down.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rck_cell
  import rck_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rck_ctrl_t         ctrl,
  input  wire logic [BASE_W-1:0] fwd_in,   // from lower neighbor (or new base)
  input  wire logic [BASE_W-1:0] rc_in,    // from upper neighbor
  output logic      [BASE_W-1:0] fwd_q,
  output logic      [BASE_W-1:0] rc_q,
  output logic      [BASE_W-1:0] fwd_nxt,
  output logic      [BASE_W-1:0] rc_nxt
);

  localparam logic [KW-1:0] POS = KW'(IDX);

  logic [BASE_W-1:0] fwd_r;
  logic [BASE_W-1:0] rc_r;
  logic              active;
  logic              is_top;

  assign active = POS < ctrl.k;
  assign is_top = POS == (ctrl.k - KW'(1));

  always_comb begin
    fwd_nxt = fwd_r;
    rc_nxt  = rc_r;
    if (ctrl.clear) begin
      fwd_nxt = '0;
      rc_nxt  = '0;
    end else if (ctrl.push) begin
      fwd_nxt = active ? fwd_in : '0;
      // complement of the new base ORs in at the top position
      rc_nxt  = active ? (rc_in | (is_top ? ~ctrl.sym : '0)) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= '0;
      rc_r  <= '0;
    end else begin
      fwd_r <= fwd_nxt;
      rc_r  <= rc_nxt;
    end
  end

  assign fwd_q = fwd_r;
  assign rc_q  = rc_r;

endmodule

`default_nettype wire

// ----- rtl/rolling_canonical_kmer.sv -----
// ----------------------------------------------------------------------------
// rolling_canonical_kmer
// Rolling forward / reverse-complement k-mer builder with canonical select.
// ----------------------------------------------------------------------------
// Takes one request per cycle while the output can drain: every accepted base
// shifts through a row of MAX_K two-bit cells in the same cycle, the new words
// are compared, and the result lands in an output register in the next cycle.
// Sustained rate is one base per clock, set by the cell shift plus a 64-bit
// compare; the input stays ready while a result waits, as long as out_tready
// lets the output register drain. A clear (tuser=1) or a symbol above 3 resets
// the k-mer state and returns a cleared result. kmer_size is 1..MAX_K (0 acts
// as 1, larger values as MAX_K); write it only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module rolling_canonical_kmer
  import rck_pkg::*;
#(
  parameter int MAX_K = MAX_K_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // config
  input  wire logic                   cfg_we,
  input  wire logic [KW-1:0]          cfg_wdata,    // kmer_size
  // input stream
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,     // [7:0] symbol
  input  wire logic                   in_tuser,     // command
  // result stream
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [63:0] forward_word, [127:64] reverse_word, [128] forward_canonical,
  // [129] kmer_full, [135:130] fill_count, [137:136] dropped_base,
  // [139:138] newest_base, [140] cleared, [143:141] zero
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  logic [KW-1:0]          ksize_r;
  logic [KW-1:0]          k_eff;
  logic [KW-1:0]          count_r;
  logic [KW-1:0]          count_nxt;
  logic                   min_r;
  logic                   min_nxt;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TDATA_W-1:0] out_data_nxt;

  logic                   accept;
  logic                   do_clear;
  rck_ctrl_t              ctrl;

  logic [BASE_W-1:0] fwd_q   [MAX_K];
  logic [BASE_W-1:0] rc_q    [MAX_K];
  logic [BASE_W-1:0] fwd_nxt [MAX_K];
  logic [BASE_W-1:0] rc_nxt  [MAX_K];

  logic [WORD_W-1:0] fwd_word;
  logic [WORD_W-1:0] rc_word;
  logic [BASE_W-1:0] dropped;
  logic [KW:0]       count_inc;

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ksize_r <= K_RESET;
    end else if (cfg_we) begin
      ksize_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (ksize_r == '0) begin
      k_eff = KW'(1);
    end else if (ksize_r > KW'(MAX_K)) begin
      k_eff = KW'(MAX_K);
    end else begin
      k_eff = ksize_r;
    end
  end

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign do_clear  = (rck_cmd_t'(in_tuser) == CMD_CLEAR) ||
                     (in_tdata[SYM_W-1:BASE_W] != '0);

  assign ctrl.push  = accept && !do_clear;
  assign ctrl.clear = accept && do_clear;
  assign ctrl.k     = k_eff;
  assign ctrl.sym   = in_tdata[BASE_W-1:0];

  // cell row
  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    logic [BASE_W-1:0] f_in;
    logic [BASE_W-1:0] r_in;
    if (i == 0) begin : g_head
      assign f_in = in_tdata[BASE_W-1:0];
    end else begin : g_link_f
      assign f_in = fwd_q[i-1];
    end
    if (i == MAX_K - 1) begin : g_tail
      assign r_in = '0;
    end else begin : g_link_r
      assign r_in = rc_q[i+1];
    end

    rck_cell #(
      .IDX(i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .fwd_in  (f_in),
      .rc_in   (r_in),
      .fwd_q   (fwd_q[i]),
      .rc_q    (rc_q[i]),
      .fwd_nxt (fwd_nxt[i]),
      .rc_nxt  (rc_nxt[i])
    );
  end

  always_comb begin
    fwd_word = '0;
    rc_word  = '0;
    dropped  = '0;
    for (int i = 0; i < MAX_K; i++) begin
      fwd_word[BASE_W*i +: BASE_W] = fwd_nxt[i];
      rc_word[BASE_W*i +: BASE_W]  = rc_nxt[i];
      if (KW'(i) == (k_eff - KW'(1))) begin
        dropped = fwd_q[i];
      end
    end
  end

  // fill count and canonical decision
  assign count_inc = {1'b0, count_r} + (KW+1)'(1);

  always_comb begin
    count_nxt = count_r;
    min_nxt   = min_r;
    if (ctrl.clear) begin
      count_nxt = '0;
      min_nxt   = 1'b1;
    end else if (ctrl.push) begin
      count_nxt = (count_inc < {1'b0, k_eff}) ? count_inc[KW-1:0] : k_eff;
      if (fwd_word < rc_word) begin
        min_nxt = 1'b1;
      end else if (fwd_word > rc_word) begin
        min_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    out_data_nxt                          = '0;
    out_data_nxt[O_FWD +: WORD_W]         = fwd_word;
    out_data_nxt[O_REV +: WORD_W]         = rc_word;
    out_data_nxt[O_CANON]                 = min_nxt;
    out_data_nxt[O_FULL]                  = count_nxt == k_eff;
    out_data_nxt[O_FILL +: KW]            = count_nxt;
    out_data_nxt[O_DROP +: BASE_W]        = do_clear ? '0 : dropped;
    out_data_nxt[O_NEW +: BASE_W]         = fwd_word[BASE_W-1:0];
    out_data_nxt[O_CLR]                   = do_clear;
    out_data_nxt[OUT_TDATA_W-1:O_USED]    = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      min_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      min_r   <= min_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ----- rtl/rck_checker.sv -----
// ----------------------------------------------------------------------------
// rck_checker
// Port-level checks for the rolling canonical k-mer builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rck_checker
  import rck_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a cleared result carries empty words and the reset decision
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[O_CLR] |->
      out_tdata[O_FWD +: WORD_W] == '0 && out_tdata[O_REV +: WORD_W] == '0 &&
      out_tdata[O_FILL +: KW] == '0 && out_tdata[O_CANON] &&
      !out_tdata[O_FULL])
    else $error("cleared result not empty");

  // a push always leaves at least one base stored
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[O_CLR] |-> out_tdata[O_FILL +: KW] != '0)
    else $error("push left fill count at zero");

  // the input side is never blocked while the output register is empty
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // every accepted request shows a result in the next cycle
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted request produced no result");

endmodule

bind rolling_canonical_kmer rck_checker u_rck_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ----- bench/tb_rolling_canonical_kmer.sv -----
// ----------------------------------------------------------------------------
// tb_rolling_canonical_kmer
// Self-checking bench for the rolling canonical k-mer builder.
// ----------------------------------------------------------------------------
// Each accepted request runs through a local copy of the k-mer state: forward
// and reverse-complement words, fill count, canonical flag and dropped base.
// The predicted result is queued and compared field by field against every
// result taken from the output stream. Directed cases cover both commands,
// invalid symbols, palindromic ties and out-of-range sizes. Random streams
// then run at several k values, including size changes without a clear,
// under four sender/receiver idle mixes.
`timescale 1ns / 1ps

module tb_rolling_canonical_kmer;
  import rck_pkg::*;

  localparam int KMAX        = MAX_K_DEF;
  localparam int CYCLE_LIMIT = 300000;
  localparam int MAX_REPORTS = 100;

  typedef struct {
    logic [WORD_W-1:0] fwd;
    logic [WORD_W-1:0] rev;
    logic              canon;
    logic              full;
    logic [KW-1:0]     fill;
    logic [BASE_W-1:0] drop;
    logic [BASE_W-1:0] newest;
    logic              cleared;
  } kmer_result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [KW-1:0]          cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [7:0] symbol
  logic                   in_tuser;   // [0] command
  logic                   out_tvalid;
  logic                   out_tready;
  // [63:0] forward_word, [127:64] reverse_word, [128] forward_canonical,
  // [129] kmer_full, [135:130] fill_count, [137:136] dropped_base,
  // [139:138] newest_base, [140] cleared, [143:141] zero
  logic [OUT_TDATA_W-1:0] out_tdata;

  // predictor state
  logic [KW-1:0]     k_cfg;
  logic [WORD_W-1:0] st_fwd;
  logic [WORD_W-1:0] st_rev;
  logic [KW-1:0]     st_fill;
  logic              st_fwd_min;
  logic [BASE_W-1:0] st_drop;

  kmer_result_t pending_kmers[$];

  int send_idle_pct;
  int rcv_stall_pct;
  int errors;
  int cycles;
  int n_pushes;
  int n_clears;
  int n_checked;
  int n_full;

  rolling_canonical_kmer #(.MAX_K(KMAX)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t ns timeout: %0d results still outstanding", $time,
               pending_kmers.size());
      $display("tb_rolling_canonical_kmer NOT OK");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------------
  function automatic void clear_kmer_state();
    st_fwd     = '0;
    st_rev     = '0;
    st_fill    = '0;
    st_fwd_min = 1'b1;
    st_drop    = '0;
  endfunction

  function automatic kmer_result_t roll_kmer(rck_cmd_t cmd, logic [7:0] sym);
    kmer_result_t      r;
    int unsigned       k;
    int unsigned       top;
    logic [WORD_W-1:0] mask;
    logic [BASE_W-1:0] comp;
    k = (k_cfg == 0) ? 1 : ((k_cfg > KMAX) ? KMAX : k_cfg);
    top = 2 * k - 2;
    mask = (k >= 32) ? '1 : ((64'd1 << (2 * k)) - 64'd1);
    r.cleared = 1'b0;
    if (cmd == CMD_CLEAR || sym > 8'd3) begin
      clear_kmer_state();
      r.cleared = 1'b1;
    end else begin
      st_drop = st_fwd[top +: 2];
      st_fwd  = ((st_fwd << 2) | WORD_W'(sym[1:0])) & mask;
      // complement enters at the top of the reverse word
      comp    = ~sym[1:0];
      st_rev  = ((st_rev >> 2) | (WORD_W'(comp) << top)) & mask;
      if (st_fwd < st_rev) st_fwd_min = 1'b1;
      else if (st_fwd > st_rev) st_fwd_min = 1'b0;
      if (int'(st_fill) + 1 < k) st_fill = st_fill + 1'b1;
      else st_fill = KW'(k);
    end
    r.fwd    = st_fwd;
    r.rev    = st_rev;
    r.canon  = st_fwd_min;
    r.full   = (st_fill == KW'(k));
    r.fill   = st_fill;
    r.drop   = st_drop;
    r.newest = st_fwd[1:0];
    return r;
  endfunction

  // ------------------------------------------------------------------------
  // result checking
  // ------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t ns mismatch %s: expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    kmer_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_kmers.size() == 0) begin
        errors++;
        $display("%0t ns unexpected result: expected none, got %h", $time, out_tdata);
      end else begin
        want = pending_kmers.pop_front();
        n_checked++;
        if (want.full) n_full++;
        check_field("forward_word", want.fwd, out_tdata[O_FWD +: WORD_W]);
        check_field("reverse_word", want.rev, out_tdata[O_REV +: WORD_W]);
        check_field("forward_canonical", want.canon, out_tdata[O_CANON]);
        check_field("kmer_full", want.full, out_tdata[O_FULL]);
        check_field("fill_count", want.fill, out_tdata[O_FILL +: KW]);
        check_field("dropped_base", want.drop, out_tdata[O_DROP +: BASE_W]);
        check_field("newest_base", want.newest, out_tdata[O_NEW +: BASE_W]);
        check_field("cleared", want.cleared, out_tdata[O_CLR]);
        check_field("padding", '0, out_tdata[OUT_TDATA_W-1:O_USED]);
      end
    end
  end

  always @(negedge clk) begin
    if (rcv_stall_pct == 0) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
  end

  // ------------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------------
  task automatic send_request(input rck_cmd_t cmd, input logic [7:0] sym);
    if (send_idle_pct != 0) begin
      while ($urandom_range(0, 99) < send_idle_pct) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= sym;
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    pending_kmers.push_back(roll_kmer(cmd, sym));
    if (cmd == CMD_CLEAR || sym > 8'd3) n_clears++;
    else n_pushes++;
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_kmers.size() != 0) @(posedge clk);
    // one output register, drained once the queue is empty
    repeat (4) @(posedge clk);
  endtask

  task automatic set_kmer_size(input logic [KW-1:0] k);
    wait_for_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= k;
    @(negedge clk);
    cfg_we <= 1'b0;
    k_cfg = k;
  endtask

  task automatic set_idle_mix(input int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  rcv_stall_pct = 0;  end
      1: begin send_idle_pct = 71; rcv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  rcv_stall_pct = 71; end
      default: begin send_idle_pct = 24; rcv_stall_pct = 24; end
    endcase
  endtask

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------
  // default size: every base code, clear command and invalid symbols
  task automatic test_commands_and_symbols();
    send_request(CMD_PUSH, 8'd0);
    send_request(CMD_PUSH, 8'd1);
    send_request(CMD_PUSH, 8'd2);
    send_request(CMD_PUSH, 8'd3);
    send_request(CMD_CLEAR, 8'hFF);
    send_request(CMD_PUSH, 8'd3);
    send_request(CMD_PUSH, 8'd4);
    send_request(CMD_PUSH, 8'd2);
    send_request(CMD_PUSH, 8'hFF);
    send_request(CMD_PUSH, 8'd1);
    send_request(CMD_CLEAR, 8'd0);
  endtask

  // k=2: AT is its own reverse complement, so ties must hold the last decision
  task automatic test_palindrome_tie();
    set_kmer_size(KW'(2));
    send_request(CMD_PUSH, 8'd3);
    send_request(CMD_PUSH, 8'd3);
    send_request(CMD_PUSH, 8'd0);
    send_request(CMD_PUSH, 8'd3);
    send_request(CMD_CLEAR, 8'd2);
    send_request(CMD_PUSH, 8'd0);
    send_request(CMD_PUSH, 8'd3);
  endtask

  // smallest size, zero and oversize values, resize without a clear
  task automatic test_size_limits();
    set_kmer_size(KW'(1));
    send_request(CMD_PUSH, 8'd3);
    send_request(CMD_PUSH, 8'd0);
    set_kmer_size(KW'(0));
    send_request(CMD_PUSH, 8'd2);
    send_request(CMD_PUSH, 8'd1);
    set_kmer_size(KW'(63));
    send_request(CMD_PUSH, 8'd1);
  endtask

  task automatic test_random_stream(input logic [KW-1:0] k, input int mode,
                                    input int count);
    int          pick;
    logic [7:0]  sym;
    rck_cmd_t    cmd;
    set_kmer_size(k);
    set_idle_mix(mode);
    for (int i = 0; i < count; i++) begin
      // hold off now and then until the pipe is empty
      if (i == count / 2 || $urandom_range(0, 299) == 0) wait_for_results();
      pick = $urandom_range(0, 199);
      if (pick < 3) begin
        cmd = CMD_CLEAR;
        sym = 8'($urandom_range(0, 255));
      end else if (pick < 6) begin
        cmd = CMD_PUSH;
        sym = 8'($urandom_range(4, 255));
      end else begin
        cmd = CMD_PUSH;
        sym = 8'($urandom_range(0, 3));
      end
      send_request(cmd, sym);
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    out_tready = 1'b0;
    errors     = 0;
    cycles     = 0;
    n_pushes   = 0;
    n_clears   = 0;
    n_checked  = 0;
    n_full     = 0;
    k_cfg      = K_RESET;
    clear_kmer_state();
    set_idle_mix(0);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_commands_and_symbols();
    test_palindrome_tie();
    test_size_limits();

    test_random_stream(KW'(32), 0, 244);
    test_random_stream(KW'(1),  1, 244);
    test_random_stream(KW'(31), 2, 244);
    test_random_stream(KW'(0),  3, 244);
    test_random_stream(KW'(63), 0, 244);
    test_random_stream(KW'(7),  1, 244);
    test_random_stream(KW'(32), 2, 244);
    test_random_stream(KW'(2),  3, 244);

    wait_for_results();
    repeat (10) @(posedge clk);
    $display("Ran %0d base pushes and %0d clears or invalid symbols at sizes 0 to 63;",
             n_pushes, n_clears);
    $display("%0d results compared, %0d of them with a full k-mer, %0d errors.",
             n_checked, n_full, errors);
    if (errors == 0) begin
      $display("tb_rolling_canonical_kmer OK");
    end else begin
      $display("tb_rolling_canonical_kmer NOT OK");
    end
    $finish;
  end

endmodule
